// ===== rtl/tcphop_pkg.sv =====
package tcphop_pkg;

	localparam int unsigned MAX_SACK_BLOCKS = 4;
	localparam int unsigned REC_SLOTS       = 3;

	// record tags
	localparam logic [3:0] TAG_SPORT  = 4'd0;
	localparam logic [3:0] TAG_DPORT  = 4'd1;
	localparam logic [3:0] TAG_SEQ    = 4'd2;
	localparam logic [3:0] TAG_ACK    = 4'd3;
	localparam logic [3:0] TAG_HDRLEN = 4'd4;
	localparam logic [3:0] TAG_FLAGS  = 4'd5;
	localparam logic [3:0] TAG_WINDOW = 4'd6;
	localparam logic [3:0] TAG_ENTRY  = 4'd7;
	localparam logic [3:0] TAG_MSS    = 4'd8;
	localparam logic [3:0] TAG_WSCALE = 4'd9;
	localparam logic [3:0] TAG_SACK   = 4'd10;
	localparam logic [3:0] TAG_TSTAMP = 4'd11;
	localparam logic [3:0] TAG_UNKNOWN = 4'd12;
	localparam logic [3:0] TAG_END    = 4'd13;

	// option kinds
	localparam logic [7:0] KIND_EOL     = 8'd0;
	localparam logic [7:0] KIND_NOP     = 8'd1;
	localparam logic [7:0] KIND_MSS     = 8'd2;
	localparam logic [7:0] KIND_WSCALE  = 8'd3;
	localparam logic [7:0] KIND_SACK_OK = 8'd4;
	localparam logic [7:0] KIND_SACK    = 8'd5;
	localparam logic [7:0] KIND_TSTAMP  = 8'd8;

	typedef struct packed {
		logic [3:0]  tag;
		logic [63:0] value;
		logic [5:0]  index;
		logic [5:0]  count;
		logic        trunc;
		logic        last;
	} rec_t;

	// records caused by one byte, slot 0 first
	typedef struct packed {
		rec_t [REC_SLOTS-1:0] rec;
		logic [1:0]           n;
	} rec_set_t;

endpackage

// ===== rtl/tcphop_core.sv =====
module tcphop_core
	import tcphop_pkg::*;
#(
	parameter int unsigned MAX_SACK_BLOCKS = tcphop_pkg::MAX_SACK_BLOCKS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output rec_set_t   recs
);

	localparam logic [2:0] PH_HDR  = 3'd0;
	localparam logic [2:0] PH_KIND = 3'd1;
	localparam logic [2:0] PH_LEN  = 3'd2;
	localparam logic [2:0] PH_DATA = 3'd3;
	localparam logic [2:0] PH_DONE = 3'd4;

	logic [2:0]  phase_q, ph;
	logic [4:0]  pos_q, pos;
	logic [63:0] acc_q, acc;
	logic [5:0]  hl_q, hl;
	logic [5:0]  bud_q, bud;
	logic [7:0]  kind_q, kind;
	logic [7:0]  olen_q, olen;
	logic [7:0]  bio_q, bio;
	logic [5:0]  vc_q, vc;
	logic [5:0]  opos_q, opos;
	logic        clr;
	logic        trunc;
	logic [7:0]  dl;
	rec_set_t    set;

	function automatic rec_set_t push(rec_set_t s, logic [3:0] tag, logic [63:0] value,
			logic [5:0] index, logic [5:0] count, logic tr, logic lst);
		rec_set_t r;
		r = s;
		if (s.n != 2'd3) begin
			r.rec[s.n] = '{tag: tag, value: value, index: index, count: count,
				trunc: tr, last: lst};
			r.n = s.n + 2'd1;
		end
		return r;
	endfunction

	function automatic logic known_kind(logic [7:0] k);
		return k == KIND_MSS || k == KIND_WSCALE || k == KIND_SACK_OK ||
			k == KIND_SACK || k == KIND_TSTAMP;
	endfunction

	function automatic logic [7:0] data_len(logic [7:0] k, logic [7:0] len);
		logic [7:0] d;
		case (k)
			KIND_MSS:     d = 8'd2;
			KIND_WSCALE:  d = 8'd1;
			KIND_SACK_OK: d = 8'd0;
			KIND_SACK:    d = {len[7:3], 3'b000};
			KIND_TSTAMP:  d = 8'd8;
			default:      d = (len >= 8'd2) ? len - 8'd2 : 8'd0;
		endcase
		return d;
	endfunction

	always_comb begin
		set   = '0;
		ph    = phase_q;
		pos   = pos_q;
		acc   = acc_q;
		hl    = hl_q;
		bud   = bud_q;
		kind  = kind_q;
		olen  = olen_q;
		bio   = bio_q;
		vc    = vc_q;
		opos  = opos_q;
		clr   = 1'b0;
		trunc = 1'b0;
		dl    = '0;
		if (ph == PH_HDR) begin
			acc = {acc[55:0], in_byte};
			case (pos)
				5'd1:  set = push(set, TAG_SPORT, {48'd0, acc[15:0]}, '0, '0, 1'b0, 1'b0);
				5'd3:  set = push(set, TAG_DPORT, {48'd0, acc[15:0]}, '0, '0, 1'b0, 1'b0);
				5'd7:  set = push(set, TAG_SEQ, {32'd0, acc[31:0]}, '0, '0, 1'b0, 1'b0);
				5'd11: set = push(set, TAG_ACK, {32'd0, acc[31:0]}, '0, '0, 1'b0, 1'b0);
				5'd12: begin
					hl  = {in_byte[7:4], 2'b00};
					set = push(set, TAG_HDRLEN, {58'd0, hl}, '0, '0, 1'b0, 1'b0);
				end
				5'd13: set = push(set, TAG_FLAGS, {56'd0, in_byte}, '0, '0, 1'b0, 1'b0);
				5'd15: set = push(set, TAG_WINDOW, {48'd0, acc[15:0]}, '0, '0, 1'b0, 1'b0);
				5'd19: begin
					bud = (hl > 6'd20) ? hl - 6'd20 : 6'd0;
					ph  = (bud != 6'd0) ? PH_KIND : PH_DONE;
				end
				default: ;
			endcase
			if (pos < 5'd19)
				pos = pos + 5'd1;
			if (in_last) begin
				trunc = (ph == PH_HDR) ? 1'b1 : (bud != 6'd0);
				set   = push(set, TAG_END, '0, '0, '0, trunc, 1'b1);
				clr   = 1'b1;
			end
		end else begin
			if (bud != 6'd0) begin
				bud = bud - 6'd1;
				case (ph)
					PH_KIND: begin
						kind = in_byte;
						olen = '0;
						vc   = '0;
						bio  = '0;
						acc  = '0;
						if (in_byte == KIND_EOL || in_byte == KIND_NOP) begin
							set  = push(set, TAG_ENTRY, {56'd0, kind}, opos, vc, 1'b0, 1'b0);
							opos = opos + 6'd1;
							ph   = (in_byte == KIND_EOL) ? PH_DONE : PH_KIND;
						end else begin
							ph = PH_LEN;
						end
					end
					PH_LEN: begin
						olen = in_byte;
						if (!known_kind(kind) && in_byte < 8'd2) begin
							set  = push(set, TAG_ENTRY, {56'd0, kind}, opos, vc, 1'b0, 1'b0);
							opos = opos + 6'd1;
							ph   = PH_DONE;
						end else if (data_len(kind, olen) == 8'd0) begin
							set  = push(set, TAG_ENTRY, {56'd0, kind}, opos, vc, 1'b0, 1'b0);
							opos = opos + 6'd1;
							ph   = PH_KIND;
						end else begin
							ph = PH_DATA;
						end
					end
					PH_DATA: begin
						dl  = data_len(kind, olen);
						acc = {acc[55:0], in_byte};
						bio = bio + 8'd1;
						case (kind)
							KIND_MSS: begin
								if (bio == 8'd2) begin
									set = push(set, TAG_MSS, {48'd0, acc[15:0]}, '0, '0,
										1'b0, 1'b0);
									vc  = 6'd1;
								end
							end
							KIND_WSCALE: begin
								set = push(set, TAG_WSCALE, {56'd0, in_byte}, '0, '0, 1'b0, 1'b0);
								vc  = 6'd1;
							end
							KIND_SACK: begin
								// block number is bio/8 - 1; drop blocks past the limit
								if (bio[2:0] == 3'd0 && bio[7:3] != 5'd0 &&
										{3'd0, bio[7:3]} <= MAX_SACK_BLOCKS[7:0]) begin
									set = push(set, TAG_SACK, acc,
										{1'b0, bio[7:3] - 5'd1}, '0, 1'b0, 1'b0);
									vc  = vc + 6'd1;
								end
							end
							KIND_TSTAMP: begin
								if (bio == 8'd8) begin
									set = push(set, TAG_TSTAMP, acc, '0, '0, 1'b0, 1'b0);
									vc  = 6'd1;
								end
							end
							default: begin
								set = push(set, TAG_UNKNOWN, {56'd0, in_byte}, '0, '0,
									1'b0, 1'b0);
								vc  = vc + 6'd1;
							end
						endcase
						if (bio >= dl) begin
							set  = push(set, TAG_ENTRY, {56'd0, kind}, opos, vc, 1'b0, 1'b0);
							opos = opos + 6'd1;
							ph   = PH_KIND;
						end
					end
					default: ;
				endcase
				// close an option cut by the end of the options area
				if (bud == 6'd0 && (ph == PH_LEN || ph == PH_DATA)) begin
					set  = push(set, TAG_ENTRY, {56'd0, kind}, opos, vc, 1'b0, 1'b0);
					opos = opos + 6'd1;
					ph   = PH_DONE;
				end
			end
			if (in_last) begin
				if (ph == PH_LEN || ph == PH_DATA) begin
					set  = push(set, TAG_ENTRY, {56'd0, kind}, opos, vc, 1'b0, 1'b0);
					opos = opos + 6'd1;
					ph   = PH_DONE;
				end
				trunc = (bud != 6'd0);
				set   = push(set, TAG_END, '0, '0, '0, trunc, 1'b1);
				clr   = 1'b1;
			end
		end
	end

	assign recs = set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			pos_q   <= '0;
			acc_q   <= '0;
			hl_q    <= '0;
			bud_q   <= '0;
			kind_q  <= '0;
			olen_q  <= '0;
			bio_q   <= '0;
			vc_q    <= '0;
			opos_q  <= '0;
		end else if (step) begin
			if (clr) begin
				phase_q <= PH_HDR;
				pos_q   <= '0;
				acc_q   <= '0;
				hl_q    <= '0;
				bud_q   <= '0;
				kind_q  <= '0;
				olen_q  <= '0;
				bio_q   <= '0;
				vc_q    <= '0;
				opos_q  <= '0;
			end else begin
				phase_q <= ph;
				pos_q   <= pos;
				acc_q   <= acc;
				hl_q    <= hl;
				bud_q   <= bud;
				kind_q  <= kind;
				olen_q  <= olen;
				bio_q   <= bio;
				vc_q    <= vc;
				opos_q  <= opos;
			end
		end
	end

endmodule

// ===== rtl/tcphop_out.sv =====
module tcphop_out
	import tcphop_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  rec_set_t    recs,
	output logic        free,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,  // rec_tag, rec_value, rec_index, rec_count, opts_truncated
	output logic        m_axis_tlast   // last_result
);

	rec_t [REC_SLOTS-1:0] slot_q;
	logic [1:0]           cnt_q;
	logic [1:0]           head_q;
	rec_t                 cur;
	logic                 take;
	logic                 at_tail;

	assign cur           = slot_q[head_q];
	assign take          = m_axis_tvalid && m_axis_tready;
	assign at_tail       = head_q == cnt_q - 2'd1;
	assign free          = (cnt_q == 2'd0) || (take && at_tail);
	assign m_axis_tvalid = cnt_q != 2'd0;
	assign m_axis_tdata  = {7'd0, cur.trunc, cur.count, cur.index, cur.value, cur.tag};
	assign m_axis_tlast  = cur.last;

	always_ff @(posedge clk) begin
		if (load)
			slot_q <= recs.rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			head_q <= '0;
		end else if (load) begin
			cnt_q  <= recs.n;
			head_q <= '0;
		end else if (take) begin
			// advance to the next record, empty after the last
			if (at_tail) begin
				cnt_q  <= '0;
				head_q <= '0;
			end else begin
				head_q <= head_q + 2'd1;
			end
		end
	end

endmodule

// ===== rtl/tcp_header_option_parser.sv =====
// TCP header and option parser.
// Slave channel: one captured segment byte per item, from header byte zero on;
// tlast marks the last captured byte of the segment.
// Master channel: tagged records (ports, sequence, ack, header length, flags,
// window, option entries and values, end); tlast marks the end record.
// An accepted byte sits in the input register and, once the result register
// is free, is decoded into zero to three records loaded into the result
// register, from which its first record is then offered.
// The result register sends one record a cycle while the receiver is ready, so
// throughput is one byte per cycle while each byte gives at most one record;
// a byte that gives several records holds the decoder until its last is taken.
// When the receiver stalls, the result register holds, the input register
// keeps one more byte, and then tready drops.
// Reset clears the parser state to the start of a segment and empties both
// registers; nothing is offered until a byte arrives.
module tcp_header_option_parser
	import tcphop_pkg::*;
#(
	parameter int unsigned MAX_SACK_BLOCKS = tcphop_pkg::MAX_SACK_BLOCKS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // seg_byte
	input  logic        s_axis_tlast,  // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,  // rec_tag, rec_value, rec_index, rec_count, opts_truncated
	output logic        m_axis_tlast   // last_result
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       free;
	logic       step;
	logic       s_fire;
	rec_set_t   recs;

	assign step          = valid_s1 && free;
	assign s_axis_tready = !valid_s1 || free;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk) begin
		if (s_fire) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	tcphop_core #(
		.MAX_SACK_BLOCKS (MAX_SACK_BLOCKS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.recs    (recs)
	);

	tcphop_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (step),
		.recs          (recs),
		.free          (free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== verif/tb_top.sv =====
import tcphop_pkg::*;

typedef enum logic [2:0] {PH_HDR, PH_KIND, PH_LEN, PH_DATA, PH_DONE} parse_phase_e;

class tcp_record_scoreboard;
	rec_t         pending_recs[$];
	rec_t         step_recs[$];
	int           mismatches;
	bit [15:0]    byte_pos;
	parse_phase_e phase;
	bit [63:0]    acc;
	bit [7:0]     hdr_len;
	bit [7:0]     budget;
	bit [7:0]     kind;
	bit [7:0]     optlen;
	bit [7:0]     nbytes;
	bit [5:0]     nvals;
	bit [5:0]     opt_pos;

	function new();
		mismatches = 0;
		clear_state();
	endfunction

	function void clear_state();
		byte_pos = '0;
		phase    = PH_HDR;
		acc      = '0;
		hdr_len  = '0;
		budget   = '0;
		kind     = '0;
		optlen   = '0;
		nbytes   = '0;
		nvals    = '0;
		opt_pos  = '0;
	endfunction

	// one byte yields three records at most; drop any beyond that
	function void add_rec(logic [3:0] tag, logic [63:0] value, logic [5:0] index,
			logic [5:0] count, logic trunc, logic last);
		rec_t r;
		if (step_recs.size() >= REC_SLOTS)
			return;
		r.tag   = tag;
		r.value = value;
		r.index = index;
		r.count = count;
		r.trunc = trunc;
		r.last  = last;
		step_recs = {step_recs, r};
	endfunction

	function void close_option(parse_phase_e next);
		add_rec(TAG_ENTRY, {56'd0, kind}, opt_pos, nvals, 1'b0, 1'b0);
		opt_pos = opt_pos + 6'd1;
		phase   = next;
	endfunction

	function bit is_known(bit [7:0] k);
		return k == KIND_MSS || k == KIND_WSCALE || k == KIND_SACK_OK ||
			k == KIND_SACK || k == KIND_TSTAMP;
	endfunction

	function int data_len();
		case (kind)
			KIND_MSS:     return 2;
			KIND_WSCALE:  return 1;
			KIND_SACK_OK: return 0;
			KIND_SACK:    return (optlen / 8) * 8;
			KIND_TSTAMP:  return 8;
			default:      return optlen >= 2 ? optlen - 2 : 0;
		endcase
	endfunction

	function void option_step(bit [7:0] b);
		int dl;
		int blk;
		case (phase)
			PH_KIND: begin
				kind   = b;
				optlen = '0;
				nvals  = '0;
				nbytes = '0;
				acc    = '0;
				if (b == KIND_EOL)
					close_option(PH_DONE);
				else if (b == KIND_NOP)
					close_option(PH_KIND);
				else
					phase = PH_LEN;
			end
			PH_LEN: begin
				optlen = b;
				// malformed length on an unknown kind stops the walk
				if (!is_known(kind) && b < 8'd2)
					close_option(PH_DONE);
				else if (data_len() == 0)
					close_option(PH_KIND);
				else
					phase = PH_DATA;
			end
			PH_DATA: begin
				dl     = data_len();
				acc    = {acc[55:0], b};
				nbytes = nbytes + 8'd1;
				case (kind)
					KIND_MSS: if (nbytes == 8'd2) begin
						add_rec(TAG_MSS, {48'd0, acc[15:0]}, '0, '0, 1'b0, 1'b0);
						nvals = 6'd1;
					end
					KIND_WSCALE: begin
						add_rec(TAG_WSCALE, {56'd0, b}, '0, '0, 1'b0, 1'b0);
						nvals = 6'd1;
					end
					KIND_SACK: if (nbytes[2:0] == 3'd0) begin
						blk = nbytes / 8 - 1;
						// surplus blocks are consumed silently
						if (blk < MAX_SACK_BLOCKS) begin
							add_rec(TAG_SACK, acc, blk[5:0], '0, 1'b0, 1'b0);
							nvals = nvals + 6'd1;
						end
					end
					KIND_TSTAMP: if (nbytes == 8'd8) begin
						add_rec(TAG_TSTAMP, acc, '0, '0, 1'b0, 1'b0);
						nvals = 6'd1;
					end
					default: begin
						add_rec(TAG_UNKNOWN, {56'd0, b}, '0, '0, 1'b0, 1'b0);
						nvals = nvals + 6'd1;
					end
				endcase
				if (int'(nbytes) >= dl)
					close_option(PH_KIND);
			end
			default: ;
		endcase
	endfunction

	function void note_byte(bit [7:0] b, bit last);
		step_recs.delete();
		if (phase == PH_HDR) begin
			acc = {acc[55:0], b};
			case (byte_pos)
				16'd1:  add_rec(TAG_SPORT, {48'd0, acc[15:0]}, '0, '0, 1'b0, 1'b0);
				16'd3:  add_rec(TAG_DPORT, {48'd0, acc[15:0]}, '0, '0, 1'b0, 1'b0);
				16'd7:  add_rec(TAG_SEQ, {32'd0, acc[31:0]}, '0, '0, 1'b0, 1'b0);
				16'd11: add_rec(TAG_ACK, {32'd0, acc[31:0]}, '0, '0, 1'b0, 1'b0);
				16'd12: begin
					hdr_len = {2'b00, b[7:4], 2'b00};
					add_rec(TAG_HDRLEN, {56'd0, hdr_len}, '0, '0, 1'b0, 1'b0);
				end
				16'd13: add_rec(TAG_FLAGS, {56'd0, b}, '0, '0, 1'b0, 1'b0);
				16'd15: add_rec(TAG_WINDOW, {48'd0, acc[15:0]}, '0, '0, 1'b0, 1'b0);
				16'd19: begin
					budget = hdr_len > 8'd20 ? hdr_len - 8'd20 : 8'd0;
					phase  = (budget != 0) ? PH_KIND : PH_DONE;
				end
				default: ;
			endcase
			if (byte_pos < 16'd19)
				byte_pos = byte_pos + 16'd1;
			if (last) begin
				add_rec(TAG_END, '0, '0, '0, (phase == PH_HDR) ? 1'b1 : (budget != 0), 1'b1);
				clear_state();
			end
		end else begin
			if (budget != 0) begin
				budget = budget - 8'd1;
				option_step(b);
				if (budget == 0 && (phase == PH_LEN || phase == PH_DATA))
					close_option(PH_DONE);
			end
			if (last) begin
				if (phase == PH_LEN || phase == PH_DATA)
					close_option(PH_DONE);
				add_rec(TAG_END, '0, '0, '0, budget != 0, 1'b1);
				clear_state();
			end
		end
		foreach (step_recs[i])
			pending_recs = {pending_recs, step_recs[i]};
	endfunction

	task flag_mismatch(string msg);
		mismatches++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	task check_record(rec_t got);
		rec_t want;
		if (pending_recs.size() == 0) begin
			flag_mismatch($sformatf("record tag %0d value %h with none expected",
				got.tag, got.value));
			return;
		end
		want = pending_recs.pop_front();
		if (got.tag !== want.tag)
			flag_mismatch($sformatf("tag %0d, expected %0d", got.tag, want.tag));
		if (got.value !== want.value)
			flag_mismatch($sformatf("tag %0d value %h, expected %h",
				want.tag, got.value, want.value));
		if (got.index !== want.index)
			flag_mismatch($sformatf("tag %0d index %0d, expected %0d",
				want.tag, got.index, want.index));
		if (got.count !== want.count)
			flag_mismatch($sformatf("tag %0d count %0d, expected %0d",
				want.tag, got.count, want.count));
		if (got.trunc !== want.trunc)
			flag_mismatch($sformatf("tag %0d truncated %b, expected %b",
				want.tag, got.trunc, want.trunc));
		if (got.last !== want.last)
			flag_mismatch($sformatf("tag %0d last %b, expected %b",
				want.tag, got.last, want.last));
	endtask
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_BYTES = 230;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_tready = 1'b1;
	logic [87:0] m_axis_tdata;
	logic        m_axis_tlast;

	tcp_record_scoreboard sb = new();
	bit [7:0] seg_bytes[$];
	int       send_calm = 0;
	int       cycles = 0;

	tcp_header_option_parser u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tlast  (s_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (send_calm > 0) begin
			send_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			send_calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic void put_random(int n);
		repeat (n) seg_bytes = {seg_bytes, 8'($urandom_range(0, 255))};
	endfunction

	function automatic void put_header(bit [3:0] doff);
		put_random(12);
		seg_bytes = {seg_bytes, {doff, 4'($urandom_range(0, 15))}};
		put_random(7);
	endfunction

	// walk the options area with mostly well-formed options; overruns cut the last one short
	function automatic void fill_options(int area);
		bit [7:0] opt[$];
		bit [7:0] k;
		int       pick;
		int       n;
		int       used;
		used = 0;
		while (used < area) begin
			opt.delete();
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				opt = {KIND_NOP};
			end else if (pick < 22) begin
				opt = {KIND_MSS, 8'd4, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
			end else if (pick < 32) begin
				opt = {KIND_WSCALE, 8'd3, 8'($urandom_range(0, 255))};
			end else if (pick < 40) begin
				opt = {KIND_SACK_OK, 8'd2};
			end else if (pick < 55) begin
				n = $urandom_range(1, 4);
				opt = {KIND_SACK, 8'(2 + 8 * n)};
				repeat (8 * n) opt = {opt, 8'($urandom_range(0, 255))};
			end else if (pick < 70) begin
				opt = {KIND_TSTAMP, 8'd10};
				repeat (8) opt = {opt, 8'($urandom_range(0, 255))};
			end else if (pick < 82) begin
				k = 8'($urandom_range(6, 255));
				if (k == KIND_TSTAMP)
					k = 8'd9;
				n = $urandom_range(2, 10);
				opt = {k, 8'(n)};
				repeat (n - 2) opt = {opt, 8'($urandom_range(0, 255))};
			end else if (pick < 87) begin
				opt = {KIND_EOL};
			end else if (pick < 92) begin
				opt = {8'($urandom_range(6, 255)), 8'($urandom_range(0, 1))};
			end else if (pick < 97) begin
				// known kind with an arbitrary length byte
				opt = {8'($urandom_range(2, 5)), 8'($urandom_range(0, 255))};
				repeat ($urandom_range(0, 4)) opt = {opt, 8'($urandom_range(0, 255))};
			end else begin
				opt = {8'($urandom_range(0, 255))};
			end
			foreach (opt[i])
				if (used < area) begin
					seg_bytes = {seg_bytes, opt[i]};
					used++;
				end
		end
	endfunction

	function automatic void build_random_segment();
		int       style;
		int       area;
		int       cut;
		bit [3:0] doff;
		seg_bytes.delete();
		style = $urandom_range(0, 99);
		if (style < 75)
			doff = 4'($urandom_range(5, 15));
		else
			doff = 4'($urandom_range(0, 15));
		put_header(doff);
		area = (doff > 5) ? doff * 4 - 20 : 0;
		if (style < 85)
			fill_options(area);
		else
			put_random(area);
		put_random($urandom_range(0, 4));
		if (style >= 88) begin
			cut = $urandom_range(1, seg_bytes.size());
			while (seg_bytes.size() > cut)
				void'(seg_bytes.pop_back());
		end
	endfunction

	task automatic send_byte(bit [7:0] b, bit last);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_byte(b, last);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_segment();
		foreach (seg_bytes[i])
			send_byte(seg_bytes[i], i == seg_bytes.size() - 1);
	endtask

	// hold the sender until every expected record is out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending_recs.size() != 0);
	endtask

	task automatic run_directed();
		// all-ones header, capture ends exactly at the end of the fixed header
		seg_bytes.delete();
		repeat (20) seg_bytes = {seg_bytes, 8'hFF};
		send_segment();
		// all-zero header: no options area, payload ignored
		seg_bytes.delete();
		repeat (20) seg_bytes = {seg_bytes, 8'h00};
		seg_bytes = {seg_bytes, 8'h5A, 8'hC3};
		send_segment();
		// capture ends inside the fixed header
		seg_bytes.delete();
		repeat (7) seg_bytes = {seg_bytes, 8'hA5};
		send_segment();
		// every known option, an unknown one, then a malformed one that stops parsing
		seg_bytes.delete();
		put_header(4'd15);
		seg_bytes = {seg_bytes, KIND_MSS, 8'd4, 8'hFF, 8'hFF, KIND_WSCALE, 8'd3, 8'h0E,
			KIND_SACK_OK, 8'd2, KIND_NOP, KIND_TSTAMP, 8'd10};
		put_random(8);
		seg_bytes = {seg_bytes, KIND_SACK, 8'd10};
		put_random(8);
		seg_bytes = {seg_bytes, 8'd200, 8'd4, 8'hAA, 8'h55, 8'd99, 8'd1};
		put_random(7);
		send_segment();
		// end of option list with junk after it
		seg_bytes.delete();
		put_header(4'd7);
		seg_bytes = {seg_bytes, KIND_WSCALE, 8'd3, 8'h00, KIND_EOL};
		put_random(4);
		send_segment();
		// capture ends inside a timestamp option
		seg_bytes.delete();
		put_header(4'd8);
		seg_bytes = {seg_bytes, KIND_TSTAMP, 8'd10};
		put_random(4);
		send_segment();
		// options area ends inside a sack option
		seg_bytes.delete();
		put_header(4'd6);
		seg_bytes = {seg_bytes, KIND_SACK, 8'd18};
		put_random(4);
		send_segment();
		// zero MSS, MSS with a short length byte, unknown kind with length zero
		seg_bytes.delete();
		put_header(4'd8);
		seg_bytes = {seg_bytes, KIND_MSS, 8'd4, 8'h00, 8'h00, KIND_MSS, 8'd1, 8'h12, 8'h34,
			8'd77, 8'd0, 8'hEE, 8'hEE};
		send_segment();
	endtask

	initial begin
		int sent;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		wait_drained();
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			build_random_segment();
			send_segment();
			sent += seg_bytes.size();
			if ($urandom_range(0, 9) == 0)
				wait_drained();
		end
		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_recs.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		int   hold;
		int   r;
		rec_t got;
		hold = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_tready) begin
				got.tag   = m_axis_tdata[3:0];
				got.value = m_axis_tdata[67:4];
				got.index = m_axis_tdata[73:68];
				got.count = m_axis_tdata[79:74];
				got.trunc = m_axis_tdata[80];
				got.last  = m_axis_tlast;
				sb.check_record(got);
			end
			if (hold > 0) begin
				hold--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					m_tready <= 1'b1;
					hold = $urandom_range(0, 12);
				end else if (r < 92) begin
					m_tready <= 1'b0;
					hold = $urandom_range(0, 2);
				end else if (r < 97) begin
					m_tready <= 1'b0;
					hold = $urandom_range(8, 30);
				end else begin
					m_tready <= 1'b1;
					hold = $urandom_range(60, 150);
				end
			end
		end
	end

endmodule
